### rtl/core/tphc_pkg.sv
`timescale 1ns / 1ps

package tphc_pkg;

    // Port widths
    localparam int IN_W      = 64;  // raw_temp, raw_press, raw_hum
    localparam int OUT_W     = 88;  // 81 result bits padded to whole bytes
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 64;

    // Pressure datapath and divider
    localparam int DIV_W     = 64;
    localparam int PRE_DEPTH = 16;  // stages ahead of the divider
    localparam int POST_DEPTH = 5;  // stages after the divider

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TEMP       = 3'd0,
        CFG_PRESS_LO   = 3'd1,
        CFG_PRESS_HI   = 3'd2,
        CFG_PRESS_NINE = 3'd3,
        CFG_HUM        = 3'd4
    } cfg_idx_t;

    // Formula constants
    localparam logic signed [32:0] T_PRESS_OFS = 33'sd128000;
    localparam logic [20:0]        PRESS_BASE  = 21'd1048576;
    localparam logic [15:0]        PRESS_SCALE = 16'd3125;
    localparam logic [63:0]        PRESS_PV_OFS = 64'h0000_8000_0000_0000;
    localparam logic [31:0]        T_HUM_OFS   = 32'd76800;
    localparam logic [31:0]        HUM_ROUND   = 32'd16384;
    localparam logic [31:0]        HUM_R_OFS   = 32'd32768;
    localparam logic [31:0]        HUM_R2_OFS  = 32'd2097152;
    localparam logic [31:0]        HUM_R3_RND  = 32'd8192;
    localparam logic [31:0]        HUM_CLAMP   = 32'd419430400;
    localparam logic [31:0]        TEMP_RND    = 32'd128;

    // Results that ride alongside the division
    typedef struct packed {
        logic [31:0] temp_centi;
        logic [16:0] hum_fine;
        logic [6:0]  hum_percent;
        logic        press_invalid;
        logic        quo_neg;
    } side_t;

    // Low 64 bits of a 64-bit word times a signed 16-bit coefficient
    function automatic logic [63:0] mul64_s16(input logic [63:0] a,
                                              input logic signed [15:0] b);
        logic signed [48:0] lo;
        logic signed [47:0] hi;
        lo = $signed({1'b0, a[31:0]}) * b;
        hi = $signed(a[63:32]) * b;
        return {{15{lo[48]}}, lo} + {hi[31:0], 32'd0};
    endfunction

    // Low 64 bits of a 64-bit word times an unsigned 16-bit value
    function automatic logic [63:0] mul64_u16(input logic [63:0] a,
                                              input logic [15:0] b);
        logic [47:0] lo;
        logic [47:0] hi;
        lo = a[31:0] * b;
        hi = a[63:32] * b;
        return {16'd0, lo} + {hi[31:0], 32'd0};
    endfunction

endpackage

### rtl/core/temp_press_hum_compensation_top.sv
`timescale 1ns / 1ps
// Throughput: one beat per cycle while the skid entry is empty; 16 front stages,
// a 64-stage one-bit-per-stage divider for pressure, 5 back stages and an output
// register with skid entry.
// Reset (aresetn low, synchronous) empties the pipeline and clears all
// calibration registers to zero.

module temp_press_hum_compensation_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // raw_temp[23:0], raw_press[47:24], raw_hum[63:48]
    input  logic [tphc_pkg::IN_W-1:0]      s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // temp_centi[31:0], press_pa[55:32], press_invalid[56],
    // hum_fine[73:57], hum_percent[80:74], zero pad[87:81]
    output logic [tphc_pkg::OUT_W-1:0]     m_tdata,
    input  logic                           cfg_wen,
    input  logic [tphc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tphc_pkg::CFG_W-1:0]     cfg_wdata
);
    import tphc_pkg::*;

    typedef struct packed {
        logic [DIV_W-1:0] ua;
        logic [DIV_W-1:0] ub;
        logic             neg;
        logic             inv;
    } press_div_t;

    // Calibration registers
    logic [47:0] cal_temp_reg;
    logic [63:0] cal_press_lo_reg;
    logic [63:0] cal_press_hi_reg;
    logic [15:0] cal_press_nine_reg;
    logic [63:0] cal_hum_reg;

    logic [15:0]        t1;
    logic signed [15:0] t2, t3;
    logic [15:0]        p1;
    logic signed [15:0] p2, p3, p4, p5, p6, p7, p8, p9;
    logic [7:0]         h1, h3;
    logic signed [15:0] h2;
    logic [11:0]        h4, h5;
    logic signed [7:0]  h6;

    // Flow control
    logic                  pipe_en;
    logic [PRE_DEPTH-1:0]  pre_vld_reg;
    logic [POST_DEPTH-1:0] post_vld_reg;

    // Front stages
    logic signed [17:0] st1_d1_reg;
    logic signed [16:0] st1_d2_reg;
    logic [20:0]        pbase_reg [8];
    logic [15:0]        adch_reg  [6];
    logic [31:0]        st2_m1_reg, st2_sq_reg;
    logic [31:0]        st3_ta_reg, st3_m2_reg;
    logic [31:0]        st4_tf_reg;
    logic [31:0]        st5_tcs_reg, st5_hx_reg;
    logic signed [32:0] st5_v_reg;
    logic [31:0]        tc_reg [11];
    logic [63:0]        st6_vv_reg;
    logic [48:0]        vp5_reg [2];
    logic [48:0]        vp2_reg [2];
    logic [31:0]        st6_h5x_reg, st6_xh6_reg, st6_xh3_reg;
    logic [63:0]        st7_t6_reg, st7_t3_reg;
    logic [31:0]        l_reg [5];
    logic [31:0]        st7_ra_reg, st7_rb_reg;
    logic [63:0]        st8_v2_reg, st8_va_reg;
    logic [31:0]        st8_rp_reg;
    logic [63:0]        st9_pv_reg, st9_dsub_reg;
    logic [31:0]        st9_rq_reg;
    logic [63:0]        st10_pm_reg, st10_dn_reg;
    logic [31:0]        st10_rr_reg;
    logic [63:0]        st11_dv_reg, st11_dn_reg;
    logic [31:0]        st11_r_reg;
    press_div_t         pd_reg [5];
    logic [31:0]        st12_x2_reg, st13_x2_reg, st14_x2_reg;
    logic [31:0]        st13_ss_reg, st14_sh_reg, st15_x3_reg;
    logic [16:0]        st16_hf_reg;

    // Front stage combinational terms
    logic signed [33:0] m1_full, sq_full;
    logic signed [31:0] sq_sh, m1_sh, m2_sh;
    logic signed [47:0] m2_full;
    logic signed [31:0] tcs_sh;
    logic signed [65:0] vv_full;
    logic signed [48:0] vp5_full, vp2_full;
    logic [43:0]        h5x_full;
    logic signed [39:0] xh6_full;
    logic [39:0]        xh3_full;
    logic [31:0]        la;
    logic signed [31:0] la_sh, xh6_sh, xh3_sh;
    logic signed [63:0] t3_sh;
    logic signed [63:0] rp_full;
    logic signed [31:0] rp_sh;
    logic signed [47:0] rr_full;
    logic signed [63:0] pm_sh;
    logic signed [31:0] rr_sh;
    logic signed [63:0] x2_full;
    logic signed [31:0] x2_sh;
    logic signed [63:0] ss_full;
    logic signed [31:0] ss_sh;
    logic signed [40:0] sh_full;
    logic signed [31:0] sh_sh;
    logic [31:0]        hum_cl;
    side_t              side_in;

    // Divider
    logic             dv_vld;
    logic [DIV_W-1:0] dv_quo;
    side_t            dv_side;

    // Back stages
    side_t              side_reg [POST_DEPTH];
    logic [63:0]        po1_q_reg, po2_q_reg, po3_q_reg, po4_q_reg;
    logic [63:0]        po2_x9_reg, po2_w2p_reg;
    logic [63:0]        po3_pp0_reg, po3_w2_reg, po4_w2_reg;
    logic [31:0]        po3_pp1_reg, po3_pp2_reg;
    logic [63:0]        po4_w1p_reg, po5_sum_reg;
    logic signed [63:0] qq2, qq3, w2_sh, w1_sh, sum_sh;
    logic [63:0]        pf;
    logic [23:0]        press_pa;
    logic [OUT_W-1:0]   res_data;

    // Output register and skid entry
    logic             out_vld_reg, skid_vld_reg;
    logic [OUT_W-1:0] out_data_reg, skid_data_reg;
    logic             push, take;

    // Calibration write port
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_temp_reg       <= '0;
            cal_press_lo_reg   <= '0;
            cal_press_hi_reg   <= '0;
            cal_press_nine_reg <= '0;
            cal_hum_reg        <= '0;
        end else if (cfg_wen) begin
            case (cfg_index)
                CFG_TEMP:       cal_temp_reg       <= cfg_wdata[47:0];
                CFG_PRESS_LO:   cal_press_lo_reg   <= cfg_wdata;
                CFG_PRESS_HI:   cal_press_hi_reg   <= cfg_wdata;
                CFG_PRESS_NINE: cal_press_nine_reg <= cfg_wdata[15:0];
                CFG_HUM:        cal_hum_reg        <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Coefficient slices
    assign t1 = cal_temp_reg[15:0];
    assign t2 = $signed(cal_temp_reg[31:16]);
    assign t3 = $signed(cal_temp_reg[47:32]);
    assign p1 = cal_press_lo_reg[15:0];
    assign p2 = $signed(cal_press_lo_reg[31:16]);
    assign p3 = $signed(cal_press_lo_reg[47:32]);
    assign p4 = $signed(cal_press_lo_reg[63:48]);
    assign p5 = $signed(cal_press_hi_reg[15:0]);
    assign p6 = $signed(cal_press_hi_reg[31:16]);
    assign p7 = $signed(cal_press_hi_reg[47:32]);
    assign p8 = $signed(cal_press_hi_reg[63:48]);
    assign p9 = $signed(cal_press_nine_reg);
    assign h1 = cal_hum_reg[7:0];
    assign h2 = $signed(cal_hum_reg[23:8]);
    assign h3 = cal_hum_reg[31:24];
    assign h4 = cal_hum_reg[43:32];
    assign h5 = cal_hum_reg[55:44];
    assign h6 = $signed(cal_hum_reg[63:56]);

    // Whole pipeline moves unless the skid entry is occupied
    assign pipe_en  = !skid_vld_reg;
    assign s_tready = pipe_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pre_vld_reg  <= '0;
            post_vld_reg <= '0;
        end else if (pipe_en) begin
            pre_vld_reg  <= {pre_vld_reg[PRE_DEPTH-2:0], s_tvalid};
            post_vld_reg <= {post_vld_reg[POST_DEPTH-2:0], dv_vld};
        end
    end

    // Front stage arithmetic
    assign m1_full  = st1_d1_reg * t2;
    assign sq_full  = st1_d2_reg * st1_d2_reg;
    assign m1_sh    = $signed(st2_m1_reg) >>> 11;
    assign sq_sh    = $signed(st2_sq_reg) >>> 12;
    assign m2_full  = sq_sh * t3;
    assign m2_sh    = $signed(st3_m2_reg) >>> 14;
    assign tcs_sh   = $signed(st5_tcs_reg) >>> 8;
    assign vv_full  = st5_v_reg * st5_v_reg;
    assign vp5_full = st5_v_reg * p5;
    assign vp2_full = st5_v_reg * p2;
    assign h5x_full = st5_hx_reg * h5;
    assign xh6_full = $signed(st5_hx_reg) * h6;
    assign xh3_full = st5_hx_reg * h3;
    assign la       = {2'b00, adch_reg[5], 14'd0} - {h4, 20'd0} - st6_h5x_reg + HUM_ROUND;
    assign la_sh    = $signed(la) >>> 15;
    assign xh6_sh   = $signed(st6_xh6_reg) >>> 10;
    assign xh3_sh   = $signed(st6_xh3_reg) >>> 11;
    assign t3_sh    = $signed(st7_t3_reg) >>> 8;
    assign rp_full  = $signed(st7_ra_reg) * $signed(st7_rb_reg);
    assign rp_sh    = $signed(st8_rp_reg) >>> 10;
    assign rr_full  = $signed(st9_rq_reg) * h2;
    assign pm_sh    = $signed(st10_pm_reg) >>> 33;
    assign rr_sh    = $signed(st10_rr_reg) >>> 14;
    assign x2_full  = $signed(l_reg[4]) * $signed(st11_r_reg);
    assign x2_sh    = $signed(st12_x2_reg) >>> 15;
    assign ss_full  = x2_sh * x2_sh;
    assign ss_sh    = $signed(st13_ss_reg) >>> 7;
    assign sh_full  = ss_sh * $signed({1'b0, h1});
    assign sh_sh    = $signed(st14_sh_reg) >>> 4;

    // Humidity clamp to 0..100 percent in Q10.22 before scaling
    always_comb begin
        if (st15_x3_reg[31]) begin
            hum_cl = '0;
        end else if (st15_x3_reg > HUM_CLAMP) begin
            hum_cl = HUM_CLAMP;
        end else begin
            hum_cl = st15_x3_reg;
        end
    end

    // Front pipeline payload
    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            // temperature differences, pressure base
            st1_d1_reg   <= $signed({1'b0, s_tdata[23:7]}) - $signed({1'b0, t1, 1'b0});
            st1_d2_reg   <= $signed({1'b0, s_tdata[23:8]}) - $signed({1'b0, t1});
            pbase_reg[0] <= PRESS_BASE - {1'b0, s_tdata[47:28]};
            adch_reg[0]  <= s_tdata[63:48];
            for (int k = 1; k < 8; k++) pbase_reg[k] <= pbase_reg[k-1];
            for (int k = 1; k < 6; k++) adch_reg[k] <= adch_reg[k-1];

            // temperature products
            st2_m1_reg <= m1_full[31:0];
            st2_sq_reg <= sq_full[31:0];
            st3_ta_reg <= m1_sh;
            st3_m2_reg <= m2_full[31:0];
            st4_tf_reg <= st3_ta_reg + m2_sh;

            // fine temperature fans out
            st5_tcs_reg <= st4_tf_reg + {st4_tf_reg[29:0], 2'b00} + TEMP_RND;
            st5_v_reg   <= $signed({st4_tf_reg[31], st4_tf_reg}) - T_PRESS_OFS;
            st5_hx_reg  <= st4_tf_reg - T_HUM_OFS;

            tc_reg[0] <= tcs_sh;
            for (int k = 1; k < 11; k++) tc_reg[k] <= tc_reg[k-1];

            // first products of pressure and humidity
            st6_vv_reg  <= vv_full[63:0];
            vp5_reg[0]  <= vp5_full;
            vp2_reg[0]  <= vp2_full;
            vp5_reg[1]  <= vp5_reg[0];
            vp2_reg[1]  <= vp2_reg[0];
            st6_h5x_reg <= h5x_full[31:0];
            st6_xh6_reg <= xh6_full[31:0];
            st6_xh3_reg <= xh3_full[31:0];

            st7_t6_reg <= mul64_s16(st6_vv_reg, p6);
            st7_t3_reg <= mul64_s16(st6_vv_reg, p3);
            l_reg[0]   <= la_sh;
            for (int k = 1; k < 5; k++) l_reg[k] <= l_reg[k-1];
            st7_ra_reg <= xh6_sh;
            st7_rb_reg <= xh3_sh + HUM_R_OFS;

            // pressure var2 and var1 sums
            st8_v2_reg <= st7_t6_reg + {vp5_reg[1][46:0], 17'd0}
                          + {{13{p4[15]}}, p4, 35'd0};
            st8_va_reg <= t3_sh + {{3{vp2_reg[1][48]}}, vp2_reg[1], 12'd0};
            st8_rp_reg <= rp_full[31:0];

            st9_pv_reg   <= st8_va_reg + PRESS_PV_OFS;
            st9_dsub_reg <= {11'd0, pbase_reg[7], 31'd0} - st8_v2_reg;
            st9_rq_reg   <= rp_sh + HUM_R2_OFS;

            st10_pm_reg <= mul64_u16(st9_pv_reg, p1);
            st10_dn_reg <= mul64_u16(st9_dsub_reg, PRESS_SCALE);
            st10_rr_reg <= rr_full[31:0] + HUM_R3_RND;

            st11_dv_reg <= pm_sh;
            st11_dn_reg <= st10_dn_reg;
            st11_r_reg  <= rr_sh;

            // divider operands as magnitudes with quotient sign
            pd_reg[0].ua  <= st11_dn_reg[63] ? 64'd0 - st11_dn_reg : st11_dn_reg;
            pd_reg[0].ub  <= st11_dv_reg[63] ? 64'd0 - st11_dv_reg : st11_dv_reg;
            pd_reg[0].neg <= st11_dn_reg[63] ^ st11_dv_reg[63];
            pd_reg[0].inv <= (st11_dv_reg == 64'd0);
            for (int k = 1; k < 5; k++) pd_reg[k] <= pd_reg[k-1];

            // humidity tail
            st12_x2_reg <= x2_full[31:0];
            st13_ss_reg <= ss_full[31:0];
            st13_x2_reg <= st12_x2_reg;
            st14_sh_reg <= sh_full[31:0];
            st14_x2_reg <= st13_x2_reg;
            st15_x3_reg <= st14_x2_reg - sh_sh;
            st16_hf_reg <= hum_cl[28:12];
        end
    end

    assign side_in.temp_centi    = tc_reg[10];
    assign side_in.hum_fine      = st16_hf_reg;
    assign side_in.hum_percent   = st16_hf_reg[16:10];
    assign side_in.press_invalid = pd_reg[4].inv;
    assign side_in.quo_neg       = pd_reg[4].neg;

    tphc_div #(
        .DIV_W (DIV_W),
        .TAG_W ($bits(side_t))
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ce      (pipe_en),
        .in_vld  (pre_vld_reg[PRE_DEPTH-1]),
        .in_num  (pd_reg[4].ua),
        .in_den  (pd_reg[4].ub),
        .in_tag  (side_in),
        .out_vld (dv_vld),
        .out_quo (dv_quo),
        .out_tag (dv_side)
    );

    // Back stage arithmetic
    assign qq2    = $signed(po1_q_reg) >>> 13;
    assign qq3    = $signed(po2_q_reg) >>> 13;
    assign w2_sh  = $signed(po2_w2p_reg) >>> 19;
    assign w1_sh  = $signed(po4_w1p_reg) >>> 25;
    assign sum_sh = $signed(po5_sum_reg) >>> 8;
    assign pf     = sum_sh + {{44{p7[15]}}, p7, 4'd0};
    assign press_pa = side_reg[4].press_invalid ? 24'd0 : pf[31:8];
    assign res_data = {7'd0, side_reg[4].hum_percent, side_reg[4].hum_fine,
                       side_reg[4].press_invalid, press_pa, side_reg[4].temp_centi};

    // Back pipeline payload
    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            side_reg[0] <= dv_side;
            for (int k = 1; k < POST_DEPTH; k++) side_reg[k] <= side_reg[k-1];

            po1_q_reg   <= dv_side.quo_neg ? 64'd0 - dv_quo : dv_quo;

            po2_q_reg   <= po1_q_reg;
            po2_x9_reg  <= mul64_s16(qq2, p9);
            po2_w2p_reg <= mul64_s16(po1_q_reg, p8);

            // p9*q*q split into 32-bit partial products
            po3_q_reg   <= po2_q_reg;
            po3_pp0_reg <= po2_x9_reg[31:0] * qq3[31:0];
            po3_pp1_reg <= 32'(po2_x9_reg[31:0] * qq3[63:32]);
            po3_pp2_reg <= 32'(po2_x9_reg[63:32] * qq3[31:0]);
            po3_w2_reg  <= w2_sh;

            po4_q_reg   <= po3_q_reg;
            po4_w1p_reg <= po3_pp0_reg + {po3_pp1_reg + po3_pp2_reg, 32'd0};
            po4_w2_reg  <= po3_w2_reg;

            po5_sum_reg <= po4_q_reg + w1_sh + po4_w2_reg;
        end
    end

    // Output register with one skid entry
    assign take = out_vld_reg && m_tready;
    assign push = pipe_en && post_vld_reg[POST_DEPTH-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (take) begin
            if (skid_vld_reg) begin
                skid_vld_reg <= 1'b0;
            end else begin
                out_vld_reg <= push;
            end
        end else if (push) begin
            if (out_vld_reg) begin
                skid_vld_reg <= 1'b1;
            end else begin
                out_vld_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            out_data_reg <= skid_vld_reg ? skid_data_reg : res_data;
        end else if (push && !out_vld_reg) begin
            out_data_reg <= res_data;
        end
        if (push && out_vld_reg && !take) begin
            skid_data_reg <= res_data;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

endmodule

### rtl/core/tphc_div.sv
`timescale 1ns / 1ps

// Pipelined unsigned restoring divider, one quotient bit per stage.
module tphc_div #(
    parameter int DIV_W = tphc_pkg::DIV_W,
    parameter int TAG_W = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             ce,
    input  logic             in_vld,
    input  logic [DIV_W-1:0] in_num,
    input  logic [DIV_W-1:0] in_den,
    input  logic [TAG_W-1:0] in_tag,
    output logic             out_vld,
    output logic [DIV_W-1:0] out_quo,
    output logic [TAG_W-1:0] out_tag
);
    import tphc_pkg::*;

    logic [DIV_W-1:0] vld_reg;
    logic [DIV_W-1:0] rem_reg [DIV_W];
    logic [DIV_W-1:0] qd_reg  [DIV_W];
    logic [DIV_W-1:0] den_reg [DIV_W];
    logic [TAG_W-1:0] tag_reg [DIV_W];

    for (genvar k = 0; k < DIV_W; k++) begin : g_stage
        logic             vld_in;
        logic [DIV_W-1:0] rem_in;
        logic [DIV_W-1:0] qd_in;
        logic [DIV_W-1:0] den_in;
        logic [TAG_W-1:0] tag_in;
        logic [DIV_W:0]   trial;
        logic [DIV_W:0]   diff;
        logic [DIV_W-1:0] rem_next;
        logic [DIV_W-1:0] qd_next;

        if (k == 0) begin : g_first
            assign vld_in = in_vld;
            assign rem_in = '0;
            assign qd_in  = in_num;
            assign den_in = in_den;
            assign tag_in = in_tag;
        end else begin : g_rest
            assign vld_in = vld_reg[k-1];
            assign rem_in = rem_reg[k-1];
            assign qd_in  = qd_reg[k-1];
            assign den_in = den_reg[k-1];
            assign tag_in = tag_reg[k-1];
        end

        // shift in the next dividend bit, subtract when it fits
        assign trial = {rem_in, qd_in[DIV_W-1]};
        assign diff  = trial - {1'b0, den_in};

        always_comb begin
            if (!diff[DIV_W]) begin
                rem_next = diff[DIV_W-1:0];
                qd_next  = {qd_in[DIV_W-2:0], 1'b1};
            end else begin
                rem_next = trial[DIV_W-1:0];
                qd_next  = {qd_in[DIV_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (ce) begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                rem_reg[k] <= rem_next;
                qd_reg[k]  <= qd_next;
                den_reg[k] <= den_in;
                tag_reg[k] <= tag_in;
            end
        end
    end

    assign out_vld = vld_reg[DIV_W-1];
    assign out_quo = qd_reg[DIV_W-1];
    assign out_tag = tag_reg[DIV_W-1];

endmodule

### rtl/core/tphc_chk.sv
`timescale 1ns / 1ps

module tphc_chk (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [tphc_pkg::OUT_W-1:0] m_tdata
);
    import tphc_pkg::*;

    // a stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // no pressure when the divisor was zero
    a_inv: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[56] |-> m_tdata[55:32] == 24'd0)
        else $error("press_pa nonzero with press_invalid");

    // whole percent agrees with the fine value, which stays within 100 percent
    a_hum: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[80:74] == m_tdata[73:67] && m_tdata[73:57] <= 17'd102400)
        else $error("humidity fields inconsistent");

    // pad bits stay zero
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[87:81] == 7'd0)
        else $error("tdata pad bits set");

    // reset empties the output
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid after reset");

endmodule

bind temp_press_hum_compensation_top tphc_chk u_chk (.*);

### sim/tb_temp_press_hum_compensation_top.sv
`timescale 1ns / 1ps

// Expected-result store for the compensation pipeline
class comp_scoreboard;
    logic [87:0] pending[$];
    int errors;

    function new();
        errors = 0;
    endfunction

    function void note_input(logic [87:0] want);
        pending.push_back(want);
    endfunction

    // returns mismatch mask per field; bit 5 set when nothing was pending
    function logic [5:0] check_result(logic [87:0] got, output logic [87:0] want);
        logic [5:0] bad;
        bad = '0;
        want = '0;
        if (pending.size() == 0) begin
            bad[5] = 1'b1;
        end else begin
            want = pending.pop_front();
            if (got[31:0]  !== want[31:0])  bad[0] = 1'b1;
            if (got[55:32] !== want[55:32]) bad[1] = 1'b1;
            if (got[56]    !== want[56])    bad[2] = 1'b1;
            if (got[73:57] !== want[73:57]) bad[3] = 1'b1;
            if (got[80:74] !== want[80:74]) bad[4] = 1'b1;
        end
        return bad;
    endfunction
endclass

module tb_temp_press_hum_compensation_top;
    import tphc_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;
    logic        cfg_wen = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_wdata = '0;

    // calibration shadow
    logic [47:0] sh_temp;
    logic [63:0] sh_plo, sh_phi;
    logic [15:0] sh_p9;
    logic [63:0] sh_hum;

    int src_idle_pct, snk_idle_pct;
    int hold_cycles = 0;
    logic hold_req = 1'b0;
    int errors;
    comp_scoreboard sb;

    temp_press_hum_compensation_top uut (.*);

    always #4 aclk = ~aclk;

    task automatic report(string what, logic [87:0] got, logic [87:0] want);
        errors++;
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    endtask

    // Bit-exact compensation of one raw sample
    function automatic logic [87:0] compensate(logic [63:0] raw);
        logic [31:0] adc_t, ta, tb, tf, tc;
        logic [31:0] t1, t2, t3;
        logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic signed [63:0] v1, v2, p, q, w1, w2, num, qa, qb;
        logic [63:0] uq;
        logic [31:0] press, p32;
        logic inval;
        logic [31:0] h1, h2, h3, h4, h5, h6, adc_h, x, l, r, hf;
        logic signed [31:0] sa, sb2;
        adc_t = {12'd0, raw[23:4]};
        t1 = {16'd0, sh_temp[15:0]};
        t2 = {{16{sh_temp[31]}}, sh_temp[31:16]};
        t3 = {{16{sh_temp[47]}}, sh_temp[47:32]};
        ta = $signed(((adc_t >> 3) - (t1 << 1)) * t2) >>> 11;
        tb = (adc_t >> 4) - t1;
        sa = $signed(tb * tb) >>> 12;
        tb = $signed(sa * $signed(t3)) >>> 14;
        tf = ta + tb;
        tc = $signed(tf * 32'd5 + 32'd128) >>> 8;

        p1 = {48'd0, sh_plo[15:0]};
        p2 = $signed(sh_plo[31:16]);
        p3 = $signed(sh_plo[47:32]);
        p4 = $signed(sh_plo[63:48]);
        p5 = $signed(sh_phi[15:0]);
        p6 = $signed(sh_phi[31:16]);
        p7 = $signed(sh_phi[47:32]);
        p8 = $signed(sh_phi[63:48]);
        p9 = $signed(sh_p9);
        v1 = $signed(tf) - 64'sd128000;
        v2 = v1 * v1 * p6;
        v2 = v2 + ((v1 * p5) <<< 17);
        v2 = v2 + (p4 <<< 35);
        v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
        v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
        press = '0;
        inval = 1'b0;
        if (v1 == 0) begin
            inval = 1'b1;
        end else begin
            p = 64'sd1048576 - $signed({44'd0, raw[47:28]});
            num = ((p <<< 31) - v2) * 64'sd3125;
            // unsigned magnitudes avoid the most-negative / -1 trap
            qa = num[63] ? -num : num;
            qb = v1[63] ? -v1 : v1;
            uq = $unsigned(qa) / $unsigned(qb);
            p = (num[63] != v1[63]) ? -$signed(uq) : $signed(uq);
            q = p >>> 13;
            w1 = (p9 * q * q) >>> 25;
            w2 = (p8 * p) >>> 19;
            p = ((p + w1 + w2) >>> 8) + (p7 <<< 4);
            p32 = p[31:0];
            press = p32 / 32'd256;
        end

        h1 = {24'd0, sh_hum[7:0]};
        h2 = {{16{sh_hum[23]}}, sh_hum[23:8]};
        h3 = {24'd0, sh_hum[31:24]};
        h4 = {20'd0, sh_hum[43:32]};
        h5 = {20'd0, sh_hum[55:44]};
        h6 = {{24{sh_hum[63]}}, sh_hum[63:56]};
        adc_h = {16'd0, raw[63:48]};
        x = tf - 32'd76800;
        l = $signed((adc_h << 14) - (h4 << 20) - h5 * x + 32'd16384) >>> 15;
        sa  = $signed(x * h6) >>> 10;
        sb2 = ($signed(x * h3) >>> 11) + 32'sd32768;
        r = $signed(sa * sb2) >>> 10;
        r = $signed((r + 32'd2097152) * h2 + 32'd8192) >>> 14;
        x = l * r;
        sa  = $signed(x) >>> 15;
        sb2 = $signed(sa * sa) >>> 7;
        sb2 = $signed(sb2 * $signed(h1)) >>> 4;
        x = x - sb2;
        if (x[31]) x = '0;
        if (x > 32'd419430400) x = 32'd419430400;
        hf = x >> 12;
        return {7'd0, hf[16:10], hf[16:0], inval, press[23:0], tc};
    endfunction

    task automatic write_cfg(cfg_idx_t idx, logic [63:0] val);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wen <= 1'b0;
        case (idx)
            CFG_TEMP:       sh_temp = val[47:0];
            CFG_PRESS_LO:   sh_plo = val;
            CFG_PRESS_HI:   sh_phi = val;
            CFG_PRESS_NINE: sh_p9 = val[15:0];
            CFG_HUM:        sh_hum = val;
            default: ;
        endcase
    endtask

    // tvalid stays up after a beat; an idle cycle or drain() drops it
    task automatic send(logic [63:0] raw);
        while (src_idle_pct > 0 && $urandom_range(99, 0) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= raw;
        do @(posedge aclk); while (!s_tready);
        sb.note_input(compensate(raw));
    endtask

    // wait for drain plus pipeline latency
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    function automatic logic [63:0] rnd_raw();
        return {$urandom(), $urandom()};
    endfunction

    // Realistic-ish calibration: typical magnitudes with random jitter
    task automatic typical_cal();
        write_cfg(CFG_TEMP, {16'd50, 16'd26000 + 16'($urandom_range(2000, 0)),
                             16'd27000 + 16'($urandom_range(2000, 0))});
        write_cfg(CFG_PRESS_LO, {16'd8000, 16'd3000, -16'sd10700,
                                 16'd36000 + 16'($urandom_range(2000, 0))});
        write_cfg(CFG_PRESS_HI, {-16'sd7, -16'sd7, -16'sd7, 16'd200});
        write_cfg(CFG_PRESS_NINE, 64'(16'd4200));
        write_cfg(CFG_HUM, {8'd30, 12'd50, 12'd320, 8'd0, 16'd360, 8'd75});
    endtask

    // Result side: random stall, one long hold-off when requested
    always @(posedge aclk) begin
        logic [87:0] want;
        logic [5:0] bad;
        if (aresetn && m_tvalid && m_tready) begin
            bad = sb.check_result(m_tdata, want);
            if (bad[5]) report("unexpected beat", m_tdata, want);
            if (bad[0]) report("temp_centi", m_tdata, want);
            if (bad[1]) report("press_pa", m_tdata, want);
            if (bad[2]) report("press_invalid", m_tdata, want);
            if (bad[3]) report("hum_fine", m_tdata, want);
            if (bad[4]) report("hum_percent", m_tdata, want);
        end
        if (hold_req && hold_cycles < 300) begin
            hold_cycles <= hold_cycles + 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= !(snk_idle_pct > 0 && $urandom_range(99, 0) < snk_idle_pct);
        end
    end

    initial begin
        #2ms;
        $display("status: fail");
        $finish;
    end

    initial begin
        int ph;
        sb = new();
        errors = 0;
        src_idle_pct = 0;
        snk_idle_pct = 0;
        sh_temp = '0; sh_plo = '0; sh_phi = '0; sh_p9 = '0; sh_hum = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset calibration gives zero divisor
        send('0);
        send('1);
        drain();
        // extremes of every register
        write_cfg(CFG_TEMP, '1);
        write_cfg(CFG_PRESS_LO, '1);
        write_cfg(CFG_PRESS_HI, '1);
        write_cfg(CFG_PRESS_NINE, 64'hFFFF);
        write_cfg(CFG_HUM, '1);
        send('0); send('1); send(64'h8000_800000_800000);
        drain();
        write_cfg(CFG_TEMP, 48'h8000_8000_FFFF);
        write_cfg(CFG_PRESS_LO, 64'h8000_8000_8000_FFFF);
        write_cfg(CFG_PRESS_HI, 64'h7FFF_7FFF_8000_7FFF);
        write_cfg(CFG_PRESS_NINE, 64'h8000);
        write_cfg(CFG_HUM, 64'h80FF_FFFF_FF80_00FF);
        send('0); send('1); send(64'hFFFF_000000_FFFFFF);
        drain();
        // typical values, humidity low/high clamps, wide raw sweep
        typical_cal();
        send({16'h6000, 24'h51A000, 24'h7E8000});
        send({16'h0000, 24'h000000, 24'h000000});
        send({16'hFFFF, 24'hFFFFF0, 24'hFFFFF0});
        send({16'h8000, 24'h800000, 24'h800000});
        send(rnd_raw()); send(rnd_raw());
        drain();

        // random phases: idle mixes, a config change each phase
        for (ph = 0; ph < 3; ph++) begin
            src_idle_pct = (ph == 0) ? 15 : (ph == 1) ? 76 : 0;
            snk_idle_pct = (ph == 0) ? 76 : (ph == 1) ? 15 : 0;
            if (ph == 1) begin
                write_cfg(CFG_TEMP, {$urandom(), $urandom()});
                write_cfg(CFG_PRESS_LO, {$urandom(), $urandom()});
                write_cfg(CFG_PRESS_HI, {$urandom(), $urandom()});
                write_cfg(CFG_PRESS_NINE, 64'($urandom_range(65535, 0)));
                write_cfg(CFG_HUM, {$urandom(), $urandom()});
            end else begin
                typical_cal();
            end
            if (ph == 2) hold_req = 1'b1;
            repeat (400) begin
                if ($urandom_range(9, 0) < 7)
                    send({16'($urandom_range(65535, 20000)),
                          24'($urandom_range(24'hA00000, 24'h300000)),
                          24'($urandom_range(24'h900000, 24'h600000))});
                else
                    send(rnd_raw());
            end
            drain();
        end

        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

### files.f
rtl/core/tphc_pkg.sv
rtl/core/tphc_div.sv
rtl/core/temp_press_hum_compensation_top.sv
rtl/core/tphc_chk.sv
sim/tb_temp_press_hum_compensation_top.sv
